FILE: sv/chained_hash_set_insert_find_defines.svh
// Assertion macros for the chained hash set checker
`ifndef CHAINED_HASH_SET_INSERT_FIND_DEFINES_SVH
`define CHAINED_HASH_SET_INSERT_FIND_DEFINES_SVH

// property checked on every rising edge outside reset
`define CHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/chs_pkg.sv
// Shared types and codes for the chained hash set
package chs_pkg;

    localparam int ROW_DEPTH_DEF    = 1024;
    localparam int BUCKET_COUNT_DEF = 2048;

    localparam logic [1:0] MODE_FIND   = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_NEXT   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] CFG_MULTISET  = 2'd0;
    localparam logic [1:0] CFG_HASH_ONLY = 2'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic        selected;
        logic [63:0] key_hash;
        logic [63:0] key_value;
        logic [9:0]  group_row;
    } item_t;

    typedef struct packed {
        logic [9:0] row_index;
        logic [1:0] status;
    } result_t;

endpackage

FILE: sv/chained_hash_set_insert_find.sv
// Top level: sequencer and table memories of the chained hash set
//
// Command channel: an item word is taken at a rising edge with start high and
// busy low; busy stays high until the result has been issued. Each item gives
// one result word on result, marked by result_valid for exactly one cycle,
// the cycle in which busy has dropped again. The receiver cannot stall.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high,
// index 0 multiset mode, 1 hash-only compare; write only while idle.
// Steps, all work running on one memory read port per table:
//   find / insert: head read, probe and compare per chain row, decide; multiset
//   append adds group, tail, append and link. next in group: group link read
//   unless past the last row. clear: one bucket head emptied per cycle.
// Reset: asynchronous; afterwards the bucket heads are swept empty, which
// holds busy high until the sweep ends, before the first item is taken.
// Throughput is one item at a time, set by the chain walk over the row memory.
module chained_hash_set_insert_find
    import chs_pkg::*;
#(
    parameter int ROW_DEPTH    = ROW_DEPTH_DEF,
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    output logic       result_valid,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);

    localparam int AW = $clog2(ROW_DEPTH);
    localparam int RW = AW + 1;
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam logic [RW-1:0] ROW_NONE = RW'(ROW_DEPTH);
    localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKET_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_HEAD, S_PROBE, S_CMP, S_DECIDE,
        S_GRP, S_TAIL, S_APPEND, S_LINK, S_NEXT
    } state_t;

    state_t        state_reg, state_next;
    item_t         item_reg, item_next;
    logic [RW-1:0] cur_reg, cur_next;
    logic [RW-1:0] steps_reg, steps_next;
    logic [RW-1:0] head_reg, head_next;
    logic [RW-1:0] match_reg, match_next;
    logic [AW-1:0] grp_reg, grp_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [RW-1:0] rows_reg, rows_next;
    logic [RW-1:0] groups_reg, groups_next;
    logic [BW-1:0] sweep_reg, sweep_next;
    logic          clr_item_reg, clr_item_next;
    logic          multiset_reg, hash_only_reg;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg, res_next;

    logic [RW-1:0] bucket_head [BUCKET_COUNT];
    logic [RW-1:0] chain_prev  [ROW_DEPTH];
    logic [63:0]   row_hash    [ROW_DEPTH];
    logic [63:0]   row_key     [ROW_DEPTH];
    logic [RW-1:0] group_next  [ROW_DEPTH];
    logic [AW-1:0] group_of_row[ROW_DEPTH];
    logic [AW-1:0] group_tail  [ROW_DEPTH];

    logic          bh_we;
    logic [BW-1:0] bh_wa, bh_ra;
    logic [RW-1:0] bh_wd, bh_q;
    logic          row_we;
    logic [AW-1:0] row_ra, row_wa;
    logic [RW-1:0] prev_wd, prev_q;
    logic [63:0]   hash_q, key_q;
    logic          gn_we;
    logic [AW-1:0] gn_wa, gn_ra;
    logic [RW-1:0] gn_wd, gn_q;
    logic [AW-1:0] gr_wd, gr_ra, gr_q;
    logic          gt_we;
    logic [AW-1:0] gt_wa, gt_wd, gt_q;
    logic          hit;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign bh_ra  = item_reg.key_hash[BW-1:0];
    assign row_ra = cur_reg[AW-1:0];
    assign gn_ra  = AW'(item_reg.group_row);
    assign gr_ra  = match_reg[AW-1:0];
    assign row_wa = rows_reg[AW-1:0];

    // shared compare unit
    assign hit = (hash_q == item_reg.key_hash) &&
                 (hash_only_reg || (key_q == item_reg.key_value));

    always_ff @(posedge clk)
    begin
        if (bh_we)
        begin
            bucket_head[bh_wa] <= bh_wd;
        end
        bh_q <= bucket_head[bh_ra];
        if (row_we)
        begin
            row_hash[row_wa]     <= item_reg.key_hash;
            row_key[row_wa]      <= item_reg.key_value;
            chain_prev[row_wa]   <= prev_wd;
            group_of_row[row_wa] <= gr_wd;
        end
        hash_q <= row_hash[row_ra];
        key_q  <= row_key[row_ra];
        prev_q <= chain_prev[row_ra];
        gr_q   <= group_of_row[gr_ra];
        if (gn_we)
        begin
            group_next[gn_wa] <= gn_wd;
        end
        gn_q <= group_next[gn_ra];
        if (gt_we)
        begin
            group_tail[gt_wa] <= gt_wd;
        end
        gt_q <= group_tail[grp_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        head_next      = head_reg;
        match_next     = match_reg;
        grp_next       = grp_reg;
        tail_next      = tail_reg;
        rows_next      = rows_reg;
        groups_next    = groups_reg;
        sweep_next     = sweep_reg;
        clr_item_next  = clr_item_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        bh_we   = 1'b0;
        bh_wa   = bh_ra;
        bh_wd   = rows_reg;
        row_we  = 1'b0;
        prev_wd = head_reg;
        gr_wd   = groups_reg[AW-1:0];
        gn_we   = 1'b0;
        gn_wa   = row_wa;
        gn_wd   = ROW_NONE;
        gt_we   = 1'b0;
        gt_wa   = groups_reg[AW-1:0];
        gt_wd   = row_wa;

        case (state_reg)
            S_CLEAR:
            begin
                bh_we      = 1'b1;
                bh_wa      = sweep_reg;
                bh_wd      = ROW_NONE;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_BUCKET)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = clr_item_reg;
                    res_next       = '{row_index: '0, status: ST_NONE};
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!item_reg.selected)
                begin
                    state_next     = S_IDLE;
                    res_valid_next = 1'b1;
                    res_next       = '{row_index: '0, status: ST_NONE};
                end
                else
                begin
                    case (item_reg.mode)
                        MODE_FIND, MODE_INSERT:
                        begin
                            state_next = S_HEAD;
                        end
                        MODE_NEXT:
                        begin
                            if (32'(item_reg.group_row) < 32'(rows_reg))
                            begin
                                state_next = S_NEXT;
                            end
                            else
                            begin
                                state_next     = S_IDLE;
                                res_valid_next = 1'b1;
                                res_next       = '{row_index: '0, status: ST_NONE};
                            end
                        end
                        default:
                        begin
                            rows_next     = '0;
                            groups_next   = '0;
                            sweep_next    = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                    endcase
                end
            end
            S_HEAD:
            begin
                head_next  = bh_q;
                cur_next   = bh_q;
                steps_next = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (cur_reg < rows_reg && steps_reg < ROW_NONE)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    match_next = ROW_NONE;
                    state_next = S_DECIDE;
                end
            end
            S_CMP:
            begin
                if (hit)
                begin
                    match_next = cur_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    cur_next   = prev_q;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_DECIDE:
            begin
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                if (item_reg.mode == MODE_FIND)
                begin
                    if (match_reg != ROW_NONE)
                    begin
                        res_next = '{row_index: 10'(match_reg), status: ST_FOUND};
                    end
                    else
                    begin
                        res_next = '{row_index: '0, status: ST_NONE};
                    end
                end
                else if (match_reg != ROW_NONE && !multiset_reg)
                begin
                    res_next = '{row_index: 10'(match_reg), status: ST_FOUND};
                end
                else if (rows_reg >= ROW_NONE)
                begin
                    res_next = '{row_index: '0, status: ST_FULL};
                end
                else if (match_reg != ROW_NONE)
                begin
                    res_valid_next = 1'b0;
                    state_next     = S_GRP;
                end
                else
                begin
                    row_we  = 1'b1;
                    prev_wd = head_reg;
                    bh_we   = 1'b1;
                    gn_we   = 1'b1;
                    if (groups_reg < ROW_NONE)
                    begin
                        gt_we       = 1'b1;
                        groups_next = groups_reg + 1'b1;
                    end
                    rows_next = rows_reg + 1'b1;
                    res_next  = '{row_index: 10'(rows_reg), status: ST_NEW};
                end
            end
            S_GRP:
            begin
                grp_next   = gr_q;
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                state_next = S_APPEND;
            end
            S_APPEND:
            begin
                tail_next = gt_q;
                row_we    = 1'b1;
                prev_wd   = ROW_NONE;
                gr_wd     = grp_reg;
                gn_we     = 1'b1;
                if (RW'(grp_reg) < groups_reg)
                begin
                    gt_we = 1'b1;
                    gt_wa = grp_reg;
                end
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (RW'(grp_reg) < groups_reg && RW'(tail_reg) < rows_reg)
                begin
                    gn_we = 1'b1;
                    gn_wa = tail_reg;
                    gn_wd = rows_reg;
                end
                rows_next      = rows_reg + 1'b1;
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                res_next       = '{row_index: 10'(match_reg), status: ST_FOUND};
            end
            S_NEXT:
            begin
                state_next     = S_IDLE;
                res_valid_next = 1'b1;
                if (gn_q < rows_reg)
                begin
                    res_next = '{row_index: 10'(gn_q), status: ST_FOUND};
                end
                else
                begin
                    res_next = '{row_index: '0, status: ST_NONE};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rows_reg      <= '0;
            groups_reg    <= '0;
            sweep_reg     <= '0;
            clr_item_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            multiset_reg  <= 1'b0;
            hash_only_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            groups_reg    <= groups_next;
            sweep_reg     <= sweep_next;
            clr_item_reg  <= clr_item_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_MULTISET:  multiset_reg  <= cfg_data;
                    CFG_HASH_ONLY: hash_only_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        head_reg  <= head_next;
        match_reg <= match_next;
        grp_reg   <= grp_next;
        tail_reg  <= tail_next;
        res_reg   <= res_next;
    end

endmodule

FILE: sv/chs_checker.sv
// Port checker for the chained hash set, bound to the top level
`include "chained_hash_set_insert_find_defines.svh"

module chs_checker
    import chs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    result_valid,
    input result_t result
);

    `CHS_ASSERT(a_res_idle, result_valid |-> !busy, "result word while busy")
    `CHS_ASSERT_NEXT(a_take_busy, start && !busy, busy, "item taken but not busy")
    `CHS_ASSERT_NEXT(a_single, result_valid, !result_valid, "result strobe held")
    `CHS_ASSERT(a_zero_row, result_valid && (result.status == ST_NONE || result.status == ST_FULL) |-> result.row_index == '0, "row index not zero")

endmodule

bind chained_hash_set_insert_find chs_checker u_chs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
